// ===== design/dlfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlfd_pkg
// Types and constants shared by the dual-link frame and line deframer.
// ----------------------------------------------------------------------------
package dlfd_pkg;

  // Byte codes seen on the links
  localparam logic [7:0] START_BYTE    = 8'hAA;
  localparam logic [7:0] END_BYTE      = 8'hFF;
  localparam logic [7:0] HEARTBEAT_CMD = 8'hF0;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_LF       = 8'h0A;

  // Configuration port
  localparam int REG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_TIMEOUT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_UART_ENABLE   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_USB_ENABLE    = 2'd2;

  // Internal run length: eight bits, enough for runs of up to 255 bytes
  localparam int CNT_W     = 8;
  localparam int OUT_CNT_W = 5;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_LINE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_READ,
    EMIT_SEND
  } emit_state_e;

  typedef struct packed {
    op_e         operation;
    logic        link;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
    logic        cmd_owner;
  } in_item_t;

  typedef struct packed {
    logic                 source_link;
    kind_e                kind;
    logic [7:0]           command;
    logic [7:0]           payload_byte;
    logic [OUT_CNT_W-1:0] payload_count;
    logic                 busy_res;
    logic                 from_owner;
    logic                 last;
  } out_item_t;

  // Run request from the link state unit to the emitter
  typedef struct packed {
    logic             valid;
    logic             link;
    kind_e            kind;
    logic [7:0]       cmd;
    logic [CNT_W-1:0] count;
    logic             busy;
    logic             owner;
  } emit_req_t;

endpackage
`default_nettype wire

// ===== design/dlfd_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlfd_in_if
// Valid/ready channel carrying one input item (byte or tick).
// ----------------------------------------------------------------------------
interface dlfd_in_if;
  logic               valid;
  logic               ready;
  dlfd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/dlfd_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlfd_out_if
// Valid/ready channel carrying one emitted frame or line byte.
// ----------------------------------------------------------------------------
interface dlfd_out_if;
  logic                valid;
  logic                ready;
  dlfd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/dlfd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dlfd_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/dlfd_link.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlfd_link
// Per-link parser state, configuration registers and store write side.
// Decides on each accepted byte whether it extends a frame, a line, or
// closes one, and hands a run request to the emitter; ticks drop stale frames.
// ----------------------------------------------------------------------------
module dlfd_link #(
  parameter int  LINK_COUNT  = 2,
  parameter int  FRAME_BYTES = 32,
  parameter int  LINE_CHARS  = 19,
  localparam int FAW = $clog2(LINK_COUNT * FRAME_BYTES),
  localparam int LAW = (LINK_COUNT * LINE_CHARS > 1) ? $clog2(LINK_COUNT * LINE_CHARS) : 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [dlfd_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [dlfd_pkg::CFG_W-1:0]          cfg_data_i,
  input  wire logic                                acc_i,
  input  wire dlfd_pkg::in_item_t                  item_i,
  output logic                                     fwr_we_o,
  output logic      [FAW-1:0]                      fwr_addr_o,
  output logic      [7:0]                          fwr_data_o,
  output logic                                     lwr_we_o,
  output logic      [LAW-1:0]                      lwr_addr_o,
  output logic      [7:0]                          lwr_data_o,
  output dlfd_pkg::emit_req_t                      req_o
);
  import dlfd_pkg::*;

  localparam int FLW = $clog2(FRAME_BYTES + 1);
  localparam int LLW = $clog2(LINE_CHARS + 1);
  localparam int LW  = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;

  logic [15:0]           timeout_q;
  logic                  uart_en_q;
  logic                  usb_en_q;
  logic [FLW-1:0]        flen_q      [LINK_COUNT];
  logic [FLW-1:0]        flen_d      [LINK_COUNT];
  logic [LINK_COUNT-1:0] in_frame_q, in_frame_d;
  logic [LINK_COUNT-1:0] ff_q, ff_d;
  logic [7:0]            cmd_q       [LINK_COUNT];
  logic [7:0]            cmd_d       [LINK_COUNT];
  logic [31:0]           last_time_q [LINK_COUNT];
  logic [31:0]           last_time_d [LINK_COUNT];
  logic [LLW-1:0]        llen_q      [LINK_COUNT];
  logic [LLW-1:0]        llen_d      [LINK_COUNT];

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 16'd200;
      uart_en_q <= 1'b1;
      usb_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_TIMEOUT: timeout_q <= cfg_data_i;
        REG_UART_ENABLE:   uart_en_q <= cfg_data_i[0];
        REG_USB_ENABLE:    usb_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Byte and tick handling
  always_comb begin
    logic [LW-1:0]  lidx;
    logic           link_ok;
    logic           en;
    logic           is_owner;
    logic           open;
    logic [FLW-1:0] len;
    logic [7:0]     b;

    flen_d      = flen_q;
    in_frame_d  = in_frame_q;
    ff_d        = ff_q;
    cmd_d       = cmd_q;
    last_time_d = last_time_q;
    llen_d      = llen_q;
    fwr_we_o    = 1'b0;
    fwr_addr_o  = '0;
    fwr_data_o  = item_i.rx_byte;
    lwr_we_o    = 1'b0;
    lwr_addr_o  = '0;
    lwr_data_o  = item_i.rx_byte;
    req_o       = '0;

    b        = item_i.rx_byte;
    lidx     = LW'(item_i.link);
    link_ok  = (int'(item_i.link) < LINK_COUNT);
    en       = item_i.link ? usb_en_q : uart_en_q;
    is_owner = (item_i.link == item_i.cmd_owner);
    open     = (b == START_BYTE) && !in_frame_q[lidx];
    len      = open ? '0 : flen_q[lidx];

    if (acc_i && item_i.operation == OP_TICK) begin
      // Drop partial frames that have been silent too long
      for (int li = 0; li < LINK_COUNT; li++) begin
        if (in_frame_q[li] && (item_i.now_ms - last_time_q[li]) > 32'(timeout_q)) begin
          in_frame_d[li] = 1'b0;
          flen_d[li]     = '0;
        end
      end
    end else if (acc_i && link_ok && en) begin
      if (in_frame_q[lidx] || open) begin
        if (len == FLW'(FRAME_BYTES)) begin
          // overflow: frame and byte are dropped
          in_frame_d[lidx] = 1'b0;
        end else begin
          fwr_we_o          = 1'b1;
          fwr_addr_o        = FAW'(lidx) * FAW'(FRAME_BYTES) + FAW'(len);
          last_time_d[lidx] = item_i.now_ms;
          ff_d[lidx]        = (b == END_BYTE);
          if (len == FLW'(1)) begin
            cmd_d[lidx] = b;
          end
          if (len >= FLW'(2) && ff_q[lidx] && b == END_BYTE) begin
            // FF FF closes the frame: emit command plus bytes after it
            in_frame_d[lidx] = 1'b0;
            flen_d[lidx]     = '0;
            req_o.valid      = 1'b1;
            req_o.link       = item_i.link;
            req_o.kind       = KIND_FRAME;
            req_o.cmd        = cmd_q[lidx];
            req_o.count      = CNT_W'(len - FLW'(1));
            req_o.busy       = !is_owner && (cmd_q[lidx] != HEARTBEAT_CMD);
            req_o.owner      = is_owner;
          end else begin
            in_frame_d[lidx] = 1'b1;
            flen_d[lidx]     = len + 1'b1;
          end
        end
      end else if (b != CHAR_CR) begin
        if (b != CHAR_LF && llen_q[lidx] < LLW'(LINE_CHARS)) begin
          lwr_we_o     = 1'b1;
          lwr_addr_o   = LAW'(lidx) * LAW'(LINE_CHARS) + LAW'(llen_q[lidx]);
          llen_d[lidx] = llen_q[lidx] + 1'b1;
        end else begin
          // end of line: LF or a full line
          llen_d[lidx] = '0;
          if (llen_q[lidx] != '0) begin
            req_o.valid = 1'b1;
            req_o.link  = item_i.link;
            req_o.kind  = KIND_LINE;
            req_o.cmd   = '0;
            req_o.count = CNT_W'(llen_q[lidx]);
            req_o.busy  = 1'b0;
            req_o.owner = is_owner;
          end
        end
      end
    end
  end

  // Link state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= '0;
      ff_q       <= '0;
      for (int li = 0; li < LINK_COUNT; li++) begin
        flen_q[li]      <= '0;
        last_time_q[li] <= '0;
        llen_q[li]      <= '0;
      end
    end else begin
      in_frame_q  <= in_frame_d;
      ff_q        <= ff_d;
      flen_q      <= flen_d;
      last_time_q <= last_time_d;
      llen_q      <= llen_d;
    end
  end

  // Command byte of the open frame
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  for (genvar gi = 0; gi < LINK_COUNT; gi++) begin : g_chk
    a_flen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      flen_q[gi] <= FLW'(FRAME_BYTES))
      else $error("frame length past frame size");
  end

endmodule
`default_nettype wire

// ===== design/dlfd_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlfd_emit
// Run sequencer: reads a stored frame or line one byte at a time from
// its store and pushes each byte into the output register.
// ----------------------------------------------------------------------------
module dlfd_emit #(
  parameter int  LINK_COUNT  = 2,
  parameter int  FRAME_BYTES = 32,
  parameter int  LINE_CHARS  = 19,
  localparam int FAW = $clog2(LINK_COUNT * FRAME_BYTES),
  localparam int LAW = (LINK_COUNT * LINE_CHARS > 1) ? $clog2(LINK_COUNT * LINE_CHARS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dlfd_pkg::emit_req_t  req_i,
  output logic                      idle_o,
  output logic      [FAW-1:0]       frd_addr_o,
  input  wire logic [7:0]           frd_data_i,
  output logic      [LAW-1:0]       lrd_addr_o,
  input  wire logic [7:0]           lrd_data_i,
  dlfd_out_if.source                out_o
);
  import dlfd_pkg::*;

  emit_state_e      state_q, state_d;
  emit_req_t        req_q;
  logic [CNT_W-1:0] idx_q;
  logic             load;
  logic             is_last;
  logic             out_valid_q;
  out_item_t        out_data_q;
  logic [7:0]       rd_byte;

  assign idle_o      = (state_q == EMIT_IDLE);
  assign is_last     = (CNT_W'(idx_q + 1'b1) == req_q.count);
  assign frd_addr_o  = FAW'(req_q.link) * FAW'(FRAME_BYTES) + FAW'(idx_q) + FAW'(2);
  assign lrd_addr_o  = LAW'(req_q.link) * LAW'(LINE_CHARS) + LAW'(idx_q);
  assign rd_byte     = (req_q.kind == KIND_LINE) ? lrd_data_i : frd_data_i;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Next state: a read state, then a send state for each byte; send waits while the output is full and not taken
  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    case (state_q)
      EMIT_IDLE: begin
        if (req_i.valid) begin
          state_d = EMIT_READ;
        end
      end
      EMIT_READ: begin
        state_d = EMIT_SEND;
      end
      EMIT_SEND: begin
        if (!out_valid_q || out_o.ready) begin
          load    = 1'b1;
          state_d = is_last ? EMIT_IDLE : EMIT_READ;
        end
      end
      default: begin
        state_d = EMIT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EMIT_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == EMIT_IDLE && req_i.valid) begin
        idx_q <= '0;
      end else if (load) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Run descriptor and output payload
  always_ff @(posedge clk_i) begin
    if (state_q == EMIT_IDLE && req_i.valid) begin
      req_q <= req_i;
    end
    if (load) begin
      out_data_q.source_link   <= req_q.link;
      out_data_q.kind          <= req_q.kind;
      out_data_q.command       <= req_q.cmd;
      out_data_q.payload_byte  <= rd_byte;
      out_data_q.payload_count <= req_q.count[OUT_CNT_W-1:0];
      out_data_q.busy_res      <= req_q.busy;
      out_data_q.from_owner    <= req_q.owner;
      out_data_q.last          <= is_last;
    end
  end

  a_req_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid |-> state_q == EMIT_IDLE)
    else $error("run request while a run is in progress");

  a_read_then_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == EMIT_READ |=> state_q == EMIT_SEND)
    else $error("read cycle not followed by send");

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != EMIT_IDLE |-> idx_q < req_q.count)
    else $error("run index past run length");

endmodule
`default_nettype wire

// ===== design/dual_link_frame_and_line_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dual_link_frame_and_line_deframer
// Two-link binary frame parser and text line assembler.
// ----------------------------------------------------------------------------
// An input transaction is either a received byte or a time tick. A byte that
// produces no output, and every tick, is taken while the block is idle. A byte
// that closes a frame or a line starts a run of N output transactions; each
// byte passes a read state for the store's registered read and a send state
// that loads the output register, held while the output stalls, and the input
// is not ready until the last byte of the run is in the output register. Frames
// and lines live in two RAMs, LINK_COUNT*FRAME_BYTES and
// LINK_COUNT*LINE_CHARS bytes deep; per-link lengths, flags and timestamps
// are kept in flip-flops. No clearing pass is needed after reset.
module dual_link_frame_and_line_deframer #(
  parameter int LINK_COUNT  = 2,
  parameter int FRAME_BYTES = 32,
  parameter int LINE_CHARS  = 19
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [dlfd_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [dlfd_pkg::CFG_W-1:0]     cfg_data_i,
  dlfd_in_if.sink                             in_i,
  dlfd_out_if.source                          out_o
);
  import dlfd_pkg::*;

  localparam int FD  = LINK_COUNT * FRAME_BYTES;
  localparam int LD  = LINK_COUNT * LINE_CHARS;
  localparam int FAW = $clog2(FD);
  localparam int LAW = (LD > 1) ? $clog2(LD) : 1;

  logic           acc;
  logic           idle;
  emit_req_t      req;
  logic           fwr_we, lwr_we;
  logic [FAW-1:0] fwr_addr, frd_addr;
  logic [LAW-1:0] lwr_addr, lrd_addr;
  logic [7:0]     fwr_data, lwr_data, frd_data, lrd_data;

  assign in_i.ready = idle;
  assign acc        = in_i.valid && idle;

  dlfd_link #(
    .LINK_COUNT  (LINK_COUNT),
    .FRAME_BYTES (FRAME_BYTES),
    .LINE_CHARS  (LINE_CHARS)
  ) u_link (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (acc),
    .item_i     (in_i.data),
    .fwr_we_o   (fwr_we),
    .fwr_addr_o (fwr_addr),
    .fwr_data_o (fwr_data),
    .lwr_we_o   (lwr_we),
    .lwr_addr_o (lwr_addr),
    .lwr_data_o (lwr_data),
    .req_o      (req)
  );

  // Frame byte store
  dlfd_ram #(
    .WIDTH (8),
    .DEPTH (FD)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fwr_we),
    .waddr_i (fwr_addr),
    .wdata_i (fwr_data),
    .raddr_i (frd_addr),
    .rdata_o (frd_data)
  );

  // Line character store
  dlfd_ram #(
    .WIDTH (8),
    .DEPTH (LD)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (lwr_we),
    .waddr_i (lwr_addr),
    .wdata_i (lwr_data),
    .raddr_i (lrd_addr),
    .rdata_o (lrd_data)
  );

  dlfd_emit #(
    .LINK_COUNT  (LINK_COUNT),
    .FRAME_BYTES (FRAME_BYTES),
    .LINE_CHARS  (LINE_CHARS)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .idle_o     (idle),
    .frd_addr_o (frd_addr),
    .frd_data_i (frd_data),
    .lrd_addr_o (lrd_addr),
    .lrd_data_i (lrd_data),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire

// ===== sim/dual_link_frame_and_line_deframer_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dual_link_frame_and_line_deframer_tb
// Self-checking bench for the dual-link frame and line deframer. A short
// table of directed bytes and ticks runs first. Random phases follow, each
// with its own timeout and link enables. Most traffic is well-formed frames
// and text lines, mixed with noise, overflows and timeouts. A cycle-free
// model of both links predicts every emitted byte, and each output
// transaction is compared field by field against it.
// ----------------------------------------------------------------------------
module dual_link_frame_and_line_deframer_tb;
  import dlfd_pkg::*;

  localparam int LINKS           = 2;
  localparam int FRAME_MAX       = 32;
  localparam int LINE_MAX        = 19;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 21;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 70;
  localparam int STALL_LIMIT     = 4000;
  localparam int PRINT_CAP       = 200;
  localparam int DIR_ROWS        = 25;

  // Directed stimulus row; n_exp/last_exp of -1 leave the check to the model
  typedef struct packed {
    op_e         op;
    logic        link;
    logic [7:0]  rx;
    logic [31:0] now;
    logic        owner;
    int          n_exp;
    int          last_exp;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  dlfd_in_if  in_ch ();
  dlfd_out_if out_ch ();

  dual_link_frame_and_line_deframer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Mirror of the block's settings and per-link state
  logic [15:0] timeout_ms;
  logic        uart_on;
  logic        usb_on;
  logic [7:0]  frm_buf   [LINKS][FRAME_MAX];
  int          frm_len   [LINKS];
  logic        frm_open  [LINKS];
  logic [31:0] frm_stamp [LINKS];
  logic [7:0]  line_buf  [LINKS][LINE_MAX];
  int          line_len  [LINKS];

  out_item_t   bytes_due [$];
  logic [7:0]  link_script [LINKS][$];
  logic [31:0] clock_ms;
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  bit          no_idle      = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_BYTE, 1'b1, 8'h41,         32'd0,          1'b0, 0, -1},  // usb off after reset
    '{OP_BYTE, 1'b0, START_BYTE,    32'd10,         1'b0, 0, -1},
    '{OP_BYTE, 1'b0, END_BYTE,      32'd11,         1'b0, 0, -1},
    '{OP_BYTE, 1'b0, END_BYTE,      32'd12,         1'b0, 1, 32'hFF},  // shortest frame
    '{OP_BYTE, 1'b0, 8'h00,         32'd13,         1'b0, 0, -1},
    '{OP_BYTE, 1'b0, CHAR_CR,       32'd14,         1'b0, 0, -1},
    '{OP_BYTE, 1'b0, CHAR_LF,       32'd15,         1'b0, 1, 32'h00},
    '{OP_BYTE, 1'b0, CHAR_LF,       32'd16,         1'b0, 0, -1},  // empty line
    '{OP_BYTE, 1'b0, START_BYTE,    32'd20,         1'b1, 0, -1},
    '{OP_BYTE, 1'b0, HEARTBEAT_CMD, 32'd21,         1'b1, 0, -1},
    '{OP_BYTE, 1'b0, END_BYTE,      32'd22,         1'b1, 0, -1},
    '{OP_BYTE, 1'b0, END_BYTE,      32'd23,         1'b1, 2, 32'hFF},  // heartbeat, no busy
    '{OP_BYTE, 1'b0, START_BYTE,    32'd30,         1'b1, 0, -1},
    '{OP_BYTE, 1'b0, 8'h12,         32'd31,         1'b1, 0, -1},
    '{OP_BYTE, 1'b0, END_BYTE,      32'd32,         1'b1, 0, -1},
    '{OP_BYTE, 1'b0, END_BYTE,      32'd33,         1'b1, 2, 32'hFF},  // busy frame
    '{OP_BYTE, 1'b0, START_BYTE,    32'hFFFF_FF00,  1'b0, 0, -1},
    '{OP_TICK, 1'b0, 8'h00,         32'h0000_0010,  1'b0, 0, -1},  // wrapped elapsed
    '{OP_BYTE, 1'b0, END_BYTE,      32'h0000_0011,  1'b0, 0, -1},
    '{OP_BYTE, 1'b0, CHAR_LF,       32'h0000_0012,  1'b1, 1, 32'hFF},
    '{OP_BYTE, 1'b0, START_BYTE,    32'd100,        1'b0, 0, -1},
    '{OP_TICK, 1'b1, 8'hFF,         32'd300,        1'b1, 0, -1},  // equal to timeout
    '{OP_TICK, 1'b0, 8'h00,         32'd301,        1'b0, 0, -1},  // one past timeout
    '{OP_BYTE, 1'b0, 8'h5A,         32'd302,        1'b0, 0, -1},
    '{OP_BYTE, 1'b0, CHAR_LF,       32'd303,        1'b0, 1, 32'h5A}
  };

  // Clock, period 2
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  task automatic flag_mismatch(string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic void push_result(logic l, kind_e k, logic [7:0] cmd, logic [7:0] data,
                                      int count, logic busy, logic own, logic fin);
    out_item_t r;
    r.source_link   = l;
    r.kind          = k;
    r.command       = cmd;
    r.payload_byte  = data;
    r.payload_count = count[OUT_CNT_W-1:0];
    r.busy_res      = busy;
    r.from_owner    = own;
    r.last          = fin;
    bytes_due.push_back(r);
  endfunction

  // Advance the link model by one accepted item; returns bytes emitted
  function automatic int deframe_step(in_item_t it);
    logic        l;
    logic        own;
    logic [7:0]  b;
    logic [7:0]  cmd;
    logic [31:0] elapsed;
    logic        busy;
    int          cnt;
    int          n;
    n = 0;
    // tick: drop frames silent for longer than the timeout, on every link
    if (it.operation == OP_TICK) begin
      for (int k = 0; k < LINKS; k++) begin
        elapsed = it.now_ms - frm_stamp[k];
        if (frm_open[k] && elapsed > {16'd0, timeout_ms}) begin
          frm_open[k] = 1'b0;
          frm_len[k]  = 0;
        end
      end
      return 0;
    end
    if ((it.link == 1'b0 && !uart_on) || (it.link == 1'b1 && !usb_on)) return 0;
    l   = it.link;
    b   = it.rx_byte;
    own = (it.link == it.cmd_owner);
    if (b == START_BYTE && !frm_open[l]) begin
      frm_len[l]   = 0;
      frm_open[l]  = 1'b1;
      frm_stamp[l] = it.now_ms;
    end
    // binary frame
    if (frm_open[l]) begin
      if (frm_len[l] >= FRAME_MAX) begin
        frm_open[l] = 1'b0;
        return 0;
      end
      frm_buf[l][frm_len[l]] = b;
      frm_len[l]++;
      frm_stamp[l] = it.now_ms;
      cnt = frm_len[l];
      if (cnt >= 2 && frm_buf[l][cnt-2] == END_BYTE && frm_buf[l][cnt-1] == END_BYTE) begin
        cmd  = frm_buf[l][1];
        busy = !own && cmd != HEARTBEAT_CMD;
        for (int k = 2; k < cnt; k++) begin
          push_result(l, KIND_FRAME, cmd, frm_buf[l][k], cnt - 2, busy, own, k == cnt - 1);
          n++;
        end
        frm_open[l] = 1'b0;
        frm_len[l]  = 0;
      end
      return n;
    end
    // text line
    if (b == CHAR_CR) return 0;
    if (b != CHAR_LF && line_len[l] < LINE_MAX) begin
      line_buf[l][line_len[l]] = b;
      line_len[l]++;
      return 0;
    end
    for (int k = 0; k < line_len[l]; k++)
      push_result(l, KIND_LINE, 8'h00, line_buf[l][k], line_len[l], 1'b0, own,
                  k == line_len[l] - 1);
    n = line_len[l];
    line_len[l] = 0;
    return n;
  endfunction

  // Drive one input transaction; the model runs at the accepting edge
  task automatic send_item(in_item_t it, output int produced);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    produced = deframe_step(it);
  endtask

  // Hold the input until every predicted byte is out and the block is idle
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
  endtask

  task automatic apply_setup(logic [15:0] tmo, logic uart, logic usb);
    write_reg(REG_FRAME_TIMEOUT, tmo);
    write_reg(REG_UART_ENABLE, {15'd0, uart});
    write_reg(REG_USB_ENABLE, {15'd0, usb});
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    timeout_ms = tmo;
    uart_on    = uart;
    usb_on     = usb;
  endtask

  // Queue up one frame, line or burst of noise for a link
  task automatic refill_script(logic l);
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 45) begin
      link_script[l].push_back(START_BYTE);
      link_script[l].push_back(($urandom_range(4) == 0) ? HEARTBEAT_CMD
                                                        : 8'($urandom_range(255)));
      // mostly fitting frames, some that overflow the store
      len = ($urandom_range(99) < 85) ? $urandom_range(26) : $urandom_range(40, 27);
      repeat (len) link_script[l].push_back(8'($urandom_range(255)));
      link_script[l].push_back(END_BYTE);
      link_script[l].push_back(END_BYTE);
    end else if (pick < 80) begin
      len = $urandom_range(24);
      repeat (len) begin
        if ($urandom_range(99) < 8) link_script[l].push_back(CHAR_CR);
        link_script[l].push_back(8'($urandom_range(126, 32)));
      end
      if ($urandom_range(99) < 85) link_script[l].push_back(CHAR_LF);
    end else begin
      repeat ($urandom_range(4, 1)) link_script[l].push_back(8'($urandom_range(255)));
    end
  endtask

  // Next random item; live is cleared for bytes sent on a disabled link
  task automatic make_random_item(output in_item_t it, output bit live);
    int   roll;
    logic l;
    logic pref;
    roll = $urandom_range(99);
    if (roll < 3) clock_ms += $urandom_range(140000, 60000);
    else if (roll < 8) clock_ms += $urandom_range(2000, 100);
    else clock_ms += $urandom_range(3);
    it.now_ms    = clock_ms;
    it.cmd_owner = 1'($urandom_range(1));
    it.link      = 1'($urandom_range(1));
    it.rx_byte   = 8'($urandom_range(255));
    live         = 1'b1;
    if ($urandom_range(99) < 8) begin
      it.operation = OP_TICK;
      return;
    end
    it.operation = OP_BYTE;
    if (uart_on && usb_on) begin
      l = 1'($urandom_range(1));
    end else begin
      pref = uart_on ? 1'b0 : 1'b1;
      l = ($urandom_range(99) < 8) ? !pref : pref;
    end
    it.link = l;
    if ((l == 1'b0 && !uart_on) || (l == 1'b1 && !usb_on)) begin
      live = 1'b0;
      return;
    end
    if (link_script[l].size() == 0) refill_script(l);
    it.rx_byte = link_script[l].pop_front();
  endtask

  // Output side: random stalls
  always @(negedge clk_i) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 6);
  end

  // Output checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (bytes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected output byte %02h", out_ch.data.payload_byte));
      end else begin
        want = bytes_due.pop_front();
        compare_field("source_link", out_ch.data.source_link, want.source_link);
        compare_field("kind", out_ch.data.kind, want.kind);
        compare_field("command", out_ch.data.command, want.command);
        compare_field("payload_byte", out_ch.data.payload_byte, want.payload_byte);
        compare_field("payload_count", out_ch.data.payload_count, want.payload_count);
        compare_field("busy_res", out_ch.data.busy_res, want.busy_res);
        compare_field("from_owner", out_ch.data.from_owner, want.from_owner);
        compare_field("last", out_ch.data.last, want.last);
      end
    end
  end

  // Watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    in_item_t it;
    int       n;
    int       sent;
    bit       live;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    timeout_ms   = 16'd200;
    uart_on      = 1'b1;
    usb_on       = 1'b0;
    clock_ms     = '0;
    for (int k = 0; k < LINKS; k++) begin
      frm_len[k]   = 0;
      frm_open[k]  = 1'b0;
      frm_stamp[k] = '0;
      line_len[k]  = 0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table, run with the reset settings
    for (int r = 0; r < DIR_ROWS; r++) begin
      it.operation = dir_rows[r].op;
      it.link      = dir_rows[r].link;
      it.rx_byte   = dir_rows[r].rx;
      it.now_ms    = dir_rows[r].now;
      it.cmd_owner = dir_rows[r].owner;
      send_item(it, n);
      if (dir_rows[r].n_exp >= 0 && n != dir_rows[r].n_exp)
        flag_mismatch($sformatf("row %0d: %0d bytes due, table says %0d",
                                r, n, dir_rows[r].n_exp));
      if (dir_rows[r].last_exp >= 0 && n > 0 &&
          bytes_due[$].payload_byte != dir_rows[r].last_exp[7:0])
        flag_mismatch($sformatf("row %0d: final byte %02h, table says %02h",
                                r, bytes_due[$].payload_byte, dir_rows[r].last_exp[7:0]));
    end

    // random phases, each under its own settings
    for (int p = 0; p < PHASES; p++) begin
      settle();
      no_idle = (p == 3);
      case (p)
        0:       apply_setup(16'd1, 1'b1, 1'b1);
        1:       apply_setup(16'hFFFF, 1'b1, 1'b1);
        2:       apply_setup(16'd50, 1'b0, 1'b1);
        3:       apply_setup(16'd200, 1'b1, 1'b1);
        4:       apply_setup(16'($urandom_range(600, 1)), 1'b1, 1'b0);
        default: apply_setup(16'($urandom_range(600, 1)), 1'b1, 1'b1);
      endcase
      clock_ms = $urandom;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // sender holds off until the output side has caught up
        if ((p == 2 && sent == 12) || $urandom_range(39) == 0) settle();
        make_random_item(it, live);
        send_item(it, n);
        if (live) sent++;
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/dlfd_pkg.sv
design/dlfd_in_if.sv
design/dlfd_out_if.sv
design/dlfd_ram.sv
design/dlfd_link.sv
design/dlfd_emit.sv
design/dual_link_frame_and_line_deframer.sv
sim/dual_link_frame_and_line_deframer_tb.sv
